@@ rtl/scld_pkg.sv @@
// shared types, constants and helper functions of the serial command line decoder
`default_nettype none
package scld_pkg;

   localparam int LINE_CHARS = 9;
   localparam int CNT_W      = $clog2(LINE_CHARS + 1);
   localparam int IDX_W      = $clog2(LINE_CHARS);

   localparam logic [7:0] KEY_CR = 8'h0d;
   localparam logic [7:0] KEY_BS = 8'h08;

   typedef logic [LINE_CHARS-1:0][7:0] line_type;
   typedef logic [CNT_W-1:0]           count_type;

   typedef enum logic [3:0] {
      CMD_NONE    = 4'd0,
      CMD_HELP    = 4'd1,
      CMD_TEST    = 4'd2,
      CMD_ADC     = 4'd3,
      CMD_VOLTAGE = 4'd4,
      CMD_CURRENT = 4'd5,
      CMD_ON      = 4'd6,
      CMD_OFF     = 4'd7,
      CMD_HALT    = 4'd8,
      CMD_RESET   = 4'd9,
      CMD_POWER   = 4'd10,
      CMD_INFO    = 4'd11,
      CMD_EMPTY   = 4'd12,
      CMD_ERROR   = 4'd13
   } cmd_type;

   typedef enum logic [2:0] {
      MODE_NONE    = 3'd0,
      MODE_TEST    = 3'd1,
      MODE_ADC     = 3'd2,
      MODE_VOLTAGE = 3'd3,
      MODE_CURRENT = 3'd4,
      MODE_POWER   = 3'd5
   } mode_type;

   typedef struct packed {
      cmd_type  command;
      mode_type mode;
      logic     mode_set;
   } match_type;

   function automatic logic [7:0] to_upper(logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b inside {[8'h61:8'h7a]}) begin
         r = b - 8'h20;
      end
      return r;
   endfunction

   // key holds up to eight characters, last character in the lowest byte
   function automatic logic key_hit(line_type l, logic [63:0] key, int len, logic whole);
      logic       hit;
      logic [7:0] c;
      hit = 1'b1;
      for (int i = 0; i < 8; i++) begin
         if (i < len) begin
            c = key[8*(len-1-i) +: 8];
            if (i < LINE_CHARS) begin
               if (l[IDX_W'(i)] != c) begin
                  hit = 1'b0;
               end
            end else begin
               hit = 1'b0;
            end
         end
      end
      if (whole && (len < LINE_CHARS)) begin
         if (l[IDX_W'(len)] != 8'h00) begin
            hit = 1'b0;
         end
      end
      return hit;
   endfunction

endpackage
`default_nettype wire

@@ rtl/scld_match.sv @@
// uppercases a finished line and matches it against the command set
`default_nettype none
module scld_match (
   input  scld_pkg::line_type  line,
   output scld_pkg::match_type result
);
   import scld_pkg::*;

   line_type uc;

   always_comb begin
      for (int i = 0; i < LINE_CHARS; i++) begin
         uc[i] = to_upper(line[i]);
      end
   end

   always_comb begin
      result.command  = CMD_ERROR;
      result.mode     = MODE_NONE;
      result.mode_set = 1'b0;
      if (key_hit(uc, 64'("HELP"), 4, 1'b0)) begin
         result.command = CMD_HELP;
      end else if (key_hit(uc, 64'("TEST"), 4, 1'b0)) begin
         result.command  = CMD_TEST;
         result.mode     = MODE_TEST;
         result.mode_set = 1'b1;
      end else if (key_hit(uc, 64'("ADC"), 3, 1'b0)) begin
         result.command  = CMD_ADC;
         result.mode     = MODE_ADC;
         result.mode_set = 1'b1;
      end else if (key_hit(uc, 64'("VOLTAGE"), 7, 1'b1)) begin
         result.command  = CMD_VOLTAGE;
         result.mode     = MODE_VOLTAGE;
         result.mode_set = 1'b1;
      end else if (key_hit(uc, 64'("CURRENT"), 7, 1'b1)) begin
         result.command  = CMD_CURRENT;
         result.mode     = MODE_CURRENT;
         result.mode_set = 1'b1;
      end else if (key_hit(uc, 64'("ON"), 2, 1'b0)) begin
         result.command = CMD_ON;
      end else if (key_hit(uc, 64'("OFF"), 3, 1'b0)) begin
         result.command = CMD_OFF;
      end else if (key_hit(uc, 64'("RST"), 3, 1'b0)) begin
         result.command = CMD_HALT;
      end else if (key_hit(uc, 64'("R"), 1, 1'b0)) begin
         result.command = CMD_RESET;
      end else if (key_hit(uc, 64'("POWER"), 5, 1'b1)) begin
         result.command  = CMD_POWER;
         result.mode     = MODE_POWER;
         result.mode_set = 1'b1;
      end else if (key_hit(uc, 64'("INFO"), 4, 1'b1)) begin
         result.command = CMD_INFO;
      end else if (uc[0] == 8'h00) begin
         result.command  = CMD_EMPTY;
         result.mode     = MODE_NONE;
         result.mode_set = 1'b1;
      end
   end

endmodule
`default_nettype wire

@@ rtl/serial_command_line_decoder_top.sv @@
// top level of the serial command line decoder: request register, line store and result register
`default_nettype none
// Takes one received byte per request and returns one result per request: the byte echoed,
// an erase flag for a backspace that removed a character, and on carriage return (rsp_tlast)
// the decoded command code. The display mode after the byte rides along in every result.
// One byte is taken every cycle while req_tready is high; a byte waits in the request register,
// and the line store and result register update together when it leaves, the command code
// coming from a combinational match of the stored line. A result waiting on rsp_tready
// holds one further request in the request register before req_tready drops.
module serial_command_line_decoder_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // echo_byte, erase_echo, command, display_mode
   output logic             rsp_tlast    // line_end
);
   import scld_pkg::*;

   logic       req_valid_ff;
   logic [7:0] req_byte_ff;
   logic       rsp_valid_ff;
   logic [7:0] echo_ff;
   logic       erase_ff;
   logic       line_end_ff;
   cmd_type    command_ff;
   line_type   line_ff;
   line_type   line_in;
   count_type  count_ff;
   count_type  count_in;
   count_type  count_dec;
   mode_type   mode_ff;
   mode_type   mode_in;
   logic       erase_in;
   logic       line_end_in;
   cmd_type    command_in;
   logic       advance;
   match_type  match;

   scld_match u_match (
      .line   (line_ff),
      .result (match)
   );

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !req_valid_ff || advance;
   assign count_dec  = count_ff - CNT_W'(1);

   always_comb begin
      line_in     = line_ff;
      count_in    = count_ff;
      mode_in     = mode_ff;
      erase_in    = 1'b0;
      line_end_in = 1'b0;
      command_in  = CMD_NONE;
      if (req_byte_ff == KEY_CR) begin
         line_in     = '0;
         count_in    = '0;
         line_end_in = 1'b1;
         command_in  = match.command;
         if (match.mode_set) begin
            mode_in = match.mode;
         end
      end else if (req_byte_ff == KEY_BS) begin
         if (count_ff != '0) begin
            count_in                      = count_dec;
            line_in[count_dec[IDX_W-1:0]] = 8'h00;
            erase_in                      = 1'b1;
         end
      end else if (count_ff < CNT_W'(LINE_CHARS)) begin
         line_in[count_ff[IDX_W-1:0]] = req_byte_ff;
         count_in                     = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         line_ff      <= '0;
         count_ff     <= '0;
         mode_ff      <= MODE_NONE;
      end else begin
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= req_valid_ff;
         end
         if (req_valid_ff && advance) begin
            line_ff  <= line_in;
            count_ff <= count_in;
            mode_ff  <= mode_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_byte_ff <= req_tdata;
      end
      if (req_valid_ff && advance) begin
         echo_ff     <= req_byte_ff;
         erase_ff    <= erase_in;
         line_end_ff <= line_end_in;
         command_ff  <= command_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = line_end_ff;
   assign rsp_tdata  = {mode_ff, command_ff, erase_ff, echo_ff};

endmodule
`default_nettype wire
